FILE: rtl/aabbfc_pkg.sv
// Shared constants, widths and result codes for the AABB frustum classifier.
`timescale 1ns / 1ps

package aabbfc_pkg;

    // Plane store depth
    localparam int NUM_PLANES = 6;

    // Field widths
    localparam int OPC_W  = 1;
    localparam int IDX_W  = 3;
    localparam int NRM_W  = 18;   // signed Q1.16
    localparam int CRD_W  = 32;   // signed Q16.16
    localparam int CLS_W  = 2;
    localparam int FRAC_W = 16;

    localparam int AXES   = 3;
    localparam int PROD_W = NRM_W + CRD_W;   // Q17.32 product
    localparam int SUM_W  = PROD_W + 2;      // sum of three products

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } opcode_t;

    typedef enum logic [CLS_W-1:0] {
        CLASS_OUTSIDE   = 2'd0,
        CLASS_INTERSECT = 2'd1,
        CLASS_INSIDE    = 2'd2
    } class_t;

endpackage

FILE: rtl/aabbfc_req_if.sv
// Request channel: plane loads and box tests.
`timescale 1ns / 1ps

interface aabbfc_req_if
    import aabbfc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic [IDX_W-1:0]         plane_index;
    logic signed [NRM_W-1:0]  normal_x;
    logic signed [NRM_W-1:0]  normal_y;
    logic signed [NRM_W-1:0]  normal_z;
    logic signed [CRD_W-1:0]  plane_offset;
    logic signed [CRD_W-1:0]  min_x;
    logic signed [CRD_W-1:0]  min_y;
    logic signed [CRD_W-1:0]  min_z;
    logic signed [CRD_W-1:0]  max_x;
    logic signed [CRD_W-1:0]  max_y;
    logic signed [CRD_W-1:0]  max_z;

    modport source (
        output valid, opcode, plane_index, normal_x, normal_y, normal_z, plane_offset,
               min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );

    modport sink (
        input  valid, opcode, plane_index, normal_x, normal_y, normal_z, plane_offset,
               min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface

FILE: rtl/aabbfc_rsp_if.sv
// Response channel: one classification per box test.
`timescale 1ns / 1ps

interface aabbfc_rsp_if
    import aabbfc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CLS_W-1:0] classification;
    logic             culled;

    modport source (
        output valid, classification, culled,
        input  ready
    );

    modport sink (
        input  valid, classification, culled,
        output ready
    );
endinterface

FILE: rtl/aabb_frustum_classify_unit.sv
// AABB versus frustum-plane classifier, top level.
`timescale 1ns / 1ps

// Classifies axis-aligned boxes against NUM_PLANES stored planes with the
// positive/negative vertex test. A load transaction (opcode 0) writes one
// plane slot at the edge where it is accepted and returns nothing; an index
// at or above NUM_PLANES is dropped. A test transaction (opcode 1) returns
// one response: outside if any plane has the box fully behind, inside if every
// plane has it fully in front, intersecting otherwise; culled flags outside.
// Throughput is one transaction per cycle unless the response stalls. A
// test moves through the stages in order: stage 1 holds the 2*3*NUM_PLANES
// 18x32 products (the planes are read at acceptance, so a later load never
// affects an earlier test), stage 2 the per-plane min/max distance sums and
// the scaled threshold, stage 3 the per-plane front/behind flags, stage 4 the
// reduced result. Each stage has its own valid bit and moves when the stage
// after it is empty or moving, so bubbles collapse and a stalled response
// holds without loss. The plane store clears to zero at reset, which makes
// every box inside until planes are loaded.
module aabb_frustum_classify_unit
    import aabbfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    aabbfc_req_if.sink    req,
    aabbfc_rsp_if.source  rsp
);

    // ---------------- plane store ----------------
    logic signed [NRM_W-1:0] nrm_reg [NUM_PLANES][AXES];
    logic signed [CRD_W-1:0] off_reg [NUM_PLANES];

    // ---------------- pipeline registers ----------------
    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic                    v1_next, v2_next, v3_next, v4_next;

    logic signed [PROD_W-1:0] pmin_reg [NUM_PLANES][AXES];
    logic signed [PROD_W-1:0] pmax_reg [NUM_PLANES][AXES];
    logic signed [PROD_W-1:0] pmin_next [NUM_PLANES][AXES];
    logic signed [PROD_W-1:0] pmax_next [NUM_PLANES][AXES];
    logic signed [CRD_W-1:0]  off1_reg [NUM_PLANES];

    logic signed [SUM_W-1:0]  dmin_reg [NUM_PLANES];
    logic signed [SUM_W-1:0]  dmax_reg [NUM_PLANES];
    logic signed [SUM_W-1:0]  thr_reg  [NUM_PLANES];
    logic signed [SUM_W-1:0]  dmin_next [NUM_PLANES];
    logic signed [SUM_W-1:0]  dmax_next [NUM_PLANES];
    logic signed [SUM_W-1:0]  thr_next  [NUM_PLANES];

    logic [NUM_PLANES-1:0]    front_reg, behind_reg;
    logic [NUM_PLANES-1:0]    front_next, behind_next;

    class_t                   cls_reg, cls_next;
    logic                     culled_reg, culled_next;

    // ---------------- handshake ----------------
    logic st1_rdy, st2_rdy, st3_rdy, st4_rdy;
    logic req_fire, load_fire;

    assign st4_rdy = !v4_reg || rsp.ready;
    assign st3_rdy = !v3_reg || st4_rdy;
    assign st2_rdy = !v2_reg || st3_rdy;
    assign st1_rdy = !v1_reg || st2_rdy;

    assign req.ready = st1_rdy;
    assign req_fire  = req.valid && st1_rdy;
    assign load_fire = req_fire && (opcode_t'(req.opcode) == OP_LOAD);

    assign v1_next = req_fire && (opcode_t'(req.opcode) == OP_TEST);
    assign v2_next = v1_reg;
    assign v3_next = v2_reg;
    assign v4_next = v3_reg;

    // ---------------- stage 0: extent select and multiply ----------------
    logic signed [CRD_W-1:0] lo [AXES];
    logic signed [CRD_W-1:0] hi [AXES];

    assign lo[0] = req.min_x;
    assign lo[1] = req.min_y;
    assign lo[2] = req.min_z;
    assign hi[0] = req.max_x;
    assign hi[1] = req.max_y;
    assign hi[2] = req.max_z;

    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                // Positive normal: min corner gives min distance. Zero or
                // negative: max corner (zero product either way for zero).
                if (nrm_reg[p][k] > 0)
                begin
                    pmin_next[p][k] = nrm_reg[p][k] * lo[k];
                    pmax_next[p][k] = nrm_reg[p][k] * hi[k];
                end
                else
                begin
                    pmin_next[p][k] = nrm_reg[p][k] * hi[k];
                    pmax_next[p][k] = nrm_reg[p][k] * lo[k];
                end
            end
        end
    end

    // ---------------- stage 1 -> 2: sums and threshold ----------------
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            dmin_next[p] = SUM_W'(pmin_reg[p][0]) + SUM_W'(pmin_reg[p][1])
                         + SUM_W'(pmin_reg[p][2]);
            dmax_next[p] = SUM_W'(pmax_reg[p][0]) + SUM_W'(pmax_reg[p][1])
                         + SUM_W'(pmax_reg[p][2]);
            // -d scaled to the product's Q.32 fraction
            thr_next[p]  = (-SUM_W'(off1_reg[p])) <<< FRAC_W;
        end
    end

    // ---------------- stage 2 -> 3: per-plane compares ----------------
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            front_next[p]  = (dmin_reg[p] >= thr_reg[p]);
            behind_next[p] = (dmax_reg[p] <= thr_reg[p]);
        end
    end

    // ---------------- stage 3 -> 4: reduce ----------------
    always_comb
    begin
        // front wins over behind on the same plane
        if (|(~front_reg & behind_reg))
        begin
            cls_next = CLASS_OUTSIDE;
        end
        else if (&front_reg)
        begin
            cls_next = CLASS_INSIDE;
        end
        else
        begin
            cls_next = CLASS_INTERSECT;
        end
        culled_next = (cls_next == CLASS_OUTSIDE);
    end

    // ---------------- plane store writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                for (int k = 0; k < AXES; k++)
                begin
                    nrm_reg[p][k] <= '0;
                end
                off_reg[p] <= '0;
            end
        end
        else
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                if (load_fire && (32'(req.plane_index) == p))
                begin
                    nrm_reg[p][0] <= req.normal_x;
                    nrm_reg[p][1] <= req.normal_y;
                    nrm_reg[p][2] <= req.normal_z;
                    off_reg[p]    <= req.plane_offset;
                end
            end
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (st1_rdy)
            begin
                v1_reg <= v1_next;
            end
            if (st2_rdy)
            begin
                v2_reg <= v2_next;
            end
            if (st3_rdy)
            begin
                v3_reg <= v3_next;
            end
            if (st4_rdy)
            begin
                v4_reg <= v4_next;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (st1_rdy && v1_next)
        begin
            pmin_reg <= pmin_next;
            pmax_reg <= pmax_next;
            off1_reg <= off_reg;
        end
        if (st2_rdy && v2_next)
        begin
            dmin_reg <= dmin_next;
            dmax_reg <= dmax_next;
            thr_reg  <= thr_next;
        end
        if (st3_rdy && v3_next)
        begin
            front_reg  <= front_next;
            behind_reg <= behind_next;
        end
        if (st4_rdy && v4_next)
        begin
            cls_reg    <= cls_next;
            culled_reg <= culled_next;
        end
    end

    assign rsp.valid          = v4_reg;
    assign rsp.classification = cls_reg;
    assign rsp.culled         = culled_reg;

endmodule

FILE: tb/aabbfc_checker.sv
// Checker for the AABB frustum classifier: tracks the plane store, predicts and compares.
`timescale 1ns / 1ps

module aabbfc_checker
    import aabbfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    aabbfc_req_if  req,
    aabbfc_rsp_if  rsp,
    output int     errors,
    output int     outstanding,
    output int     loads_seen,
    output int     loads_dropped,
    output int     tests_seen,
    output int     n_outside,
    output int     n_intersect,
    output int     n_inside
);

    // Shadow copy of the plane store
    logic signed [NRM_W-1:0] nrm_store [NUM_PLANES][AXES];
    logic signed [CRD_W-1:0] ofs_store [NUM_PLANES];

    class_t class_q[$];
    int     fail_count;
    int     rsp_count;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch on response %0d: %s", $time, rsp_count, what);
    endtask

    // Positive/negative vertex test over every stored plane, exact in 64 bits.
    function automatic class_t classify_box(input logic signed [CRD_W-1:0] lo [AXES],
                                            input logic signed [CRD_W-1:0] hi [AXES]);
        longint dmin, dmax, thr, n;
        bit     any_behind, all_front;
        int     p, a;
        any_behind = 1'b0;
        all_front  = 1'b1;
        for (p = 0; p < NUM_PLANES; p++)
        begin
            dmin = 0;
            dmax = 0;
            thr  = -(longint'(ofs_store[p]) * (longint'(1) << FRAC_W));
            for (a = 0; a < AXES; a++)
            begin
                n = longint'(nrm_store[p][a]);
                if (n > 0)
                begin
                    dmin += n * longint'(lo[a]);
                    dmax += n * longint'(hi[a]);
                end
                else
                begin
                    dmin += n * longint'(hi[a]);
                    dmax += n * longint'(lo[a]);
                end
            end
            // front wins when both hold
            if (dmin < thr)
            begin
                all_front = 1'b0;
                if (dmax <= thr)
                    any_behind = 1'b1;
            end
        end
        if (any_behind)
            return CLASS_OUTSIDE;
        else if (all_front)
            return CLASS_INSIDE;
        else
            return CLASS_INTERSECT;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic signed [CRD_W-1:0] lo [AXES];
        logic signed [CRD_W-1:0] hi [AXES];
        class_t cls;
        class_t want;
        int p, a;
        if (!rst_n)
        begin
            for (p = 0; p < NUM_PLANES; p++)
            begin
                for (a = 0; a < AXES; a++)
                    nrm_store[p][a] = '0;
                ofs_store[p] = '0;
            end
            class_q.delete();
            fail_count = 0;
            rsp_count  = 0;
            errors        <= 0;
            outstanding   <= 0;
            loads_seen    <= 0;
            loads_dropped <= 0;
            tests_seen    <= 0;
            n_outside     <= 0;
            n_intersect   <= 0;
            n_inside      <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                if (opcode_t'(req.opcode) == OP_LOAD)
                begin
                    if (req.plane_index < NUM_PLANES)
                    begin
                        nrm_store[req.plane_index][0] = req.normal_x;
                        nrm_store[req.plane_index][1] = req.normal_y;
                        nrm_store[req.plane_index][2] = req.normal_z;
                        ofs_store[req.plane_index]    = req.plane_offset;
                        loads_seen <= loads_seen + 1;
                    end
                    else
                        loads_dropped <= loads_dropped + 1;
                end
                else
                begin
                    lo[0] = req.min_x;  lo[1] = req.min_y;  lo[2] = req.min_z;
                    hi[0] = req.max_x;  hi[1] = req.max_y;  hi[2] = req.max_z;
                    cls = classify_box(lo, hi);
                    class_q.push_back(cls);
                    tests_seen <= tests_seen + 1;
                    case (cls)
                        CLASS_OUTSIDE:   n_outside   <= n_outside + 1;
                        CLASS_INTERSECT: n_intersect <= n_intersect + 1;
                        default:         n_inside    <= n_inside + 1;
                    endcase
                end
            end

            if (rsp.valid && rsp.ready)
            begin
                if (class_q.size() == 0)
                    report_mismatch("response with no box test pending");
                else
                begin
                    want = class_q.pop_front();
                    if (rsp.classification !== want)
                        report_mismatch($sformatf("classification %0d, expected %0d (%s)",
                                                  rsp.classification, want, want.name()));
                    if (rsp.culled !== (want == CLASS_OUTSIDE))
                        report_mismatch($sformatf("culled %b, expected %b",
                                                  rsp.culled, want == CLASS_OUTSIDE));
                end
                rsp_count++;
            end

            outstanding <= class_q.size();
            errors      <= fail_count;
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the AABB frustum classifier: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps

module tb;
    import aabbfc_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;   // cycles with no transaction on either side
    localparam int SETTLE_CYCLES    = 8;      // pipeline is four stages, the last one the response reg
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int HOLD_BURST_ITEMS = 40;

    localparam int ONE     = 65536;           // 1.0 in Q16.16 and Q1.16
    localparam int TEN     = 10 * ONE;
    localparam int CRD_MAX = 32'h7FFF_FFFF;
    localparam int CRD_MIN = int'(32'h8000_0000);
    localparam int NRM_MAX = 131071;
    localparam int NRM_MIN = -131072;

    typedef struct {
        opcode_t                 op;
        logic [IDX_W-1:0]        idx;
        logic signed [NRM_W-1:0] nx, ny, nz;
        logic signed [CRD_W-1:0] d;
        logic signed [CRD_W-1:0] min_x, min_y, min_z;
        logic signed [CRD_W-1:0] max_x, max_y, max_z;
    } req_item_t;

    logic clk;
    logic rst_n;

    aabbfc_req_if req();
    aabbfc_rsp_if rsp();

    int errors, outstanding, loads_seen, loads_dropped;
    int tests_seen, n_outside, n_intersect, n_inside;

    bit idle_on;        // random stalls on both sides
    bit long_hold;      // asks the receiver for one long hold-off
    int idle_cycles;

    aabb_frustum_classify_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    aabbfc_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .errors        (errors),
        .outstanding   (outstanding),
        .loads_seen    (loads_seen),
        .loads_dropped (loads_dropped),
        .tests_seen    (tests_seen),
        .n_outside     (n_outside),
        .n_intersect   (n_intersect),
        .n_inside      (n_inside)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    int  stall_left;
    bit  hold_done;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            stall_left = 0;
            hold_done  = 1'b0;
        end
        else if (stall_left > 0)
        begin
            rsp.ready <= 1'b0;
            stall_left--;
        end
        else if (long_hold && !hold_done)
        begin
            hold_done  = 1'b1;
            stall_left = LONG_HOLD_CYCLES - 1;
            rsp.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic req_item_t load_item(input int idx, input int nx, input int ny,
                                            input int nz, input int d);
        req_item_t it;
        it.op    = OP_LOAD;
        it.idx   = IDX_W'(idx);
        it.nx    = NRM_W'(nx);
        it.ny    = NRM_W'(ny);
        it.nz    = NRM_W'(nz);
        it.d     = d;
        // box fields are don't-care on a load
        it.min_x = $urandom;  it.min_y = $urandom;  it.min_z = $urandom;
        it.max_x = $urandom;  it.max_y = $urandom;  it.max_z = $urandom;
        return it;
    endfunction

    function automatic req_item_t test_item(input int lx, input int ly, input int lz,
                                            input int hx, input int hy, input int hz);
        req_item_t it;
        it.op    = OP_TEST;
        // plane fields are don't-care on a test
        it.idx   = IDX_W'($urandom);
        it.nx    = NRM_W'($urandom);
        it.ny    = NRM_W'($urandom);
        it.nz    = NRM_W'($urandom);
        it.d     = $urandom;
        it.min_x = lx;  it.min_y = ly;  it.min_z = lz;
        it.max_x = hx;  it.max_y = hy;  it.max_z = hz;
        return it;
    endfunction

    function automatic int rand_normal();
        case ($urandom_range(0, 7))
            0:       return int'($urandom);
            1:       return 0;
            2:       return $urandom_range(0, 1) ? NRM_MAX : NRM_MIN;
            default: return int'($urandom_range(0, 2 * ONE)) - ONE;
        endcase
    endfunction

    // Offsets and box centers mostly within +-64 units so every class shows up.
    function automatic int rand_span();
        case ($urandom_range(0, 7))
            0:       return int'($urandom);
            1:       return $urandom_range(0, 1) ? CRD_MAX : CRD_MIN;
            default: return int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
        endcase
    endfunction

    function automatic req_item_t rand_box();
        int lo [AXES];
        int hi [AXES];
        int c, h, a;
        for (a = 0; a < AXES; a++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                lo[a] = $urandom;
                hi[a] = $urandom;
            end
            else
            begin
                c = int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
                h = $urandom_range(0, 32'h0020_0000);
                lo[a] = c - h;
                hi[a] = c + h;
                if ($urandom_range(0, 15) == 0)
                begin
                    lo[a] = c + h;    // inverted extent
                    hi[a] = c - h;
                end
            end
        end
        return test_item(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // Holds the item on the bus until it is taken; valid stays high.
    task automatic push_item(input req_item_t it);
        req.valid        <= 1'b1;
        req.opcode       <= it.op;
        req.plane_index  <= it.idx;
        req.normal_x     <= it.nx;
        req.normal_y     <= it.ny;
        req.normal_z     <= it.nz;
        req.plane_offset <= it.d;
        req.min_x        <= it.min_x;
        req.min_y        <= it.min_y;
        req.min_z        <= it.min_z;
        req.max_x        <= it.max_x;
        req.max_y        <= it.max_y;
        req.max_z        <= it.max_z;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic send(input req_item_t it);
        int n;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 15);
            req.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        push_item(it);
    endtask

    // outstanding is a registered copy of the queue size, hence the wait on the clock before looking at it
    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int done, r;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                // slot past the store: dropped, not counted
                send(load_item($urandom_range(NUM_PLANES, 7), rand_normal(), rand_normal(),
                               rand_normal(), rand_span()));
            else if (r < 22)
            begin
                send(load_item($urandom_range(0, NUM_PLANES - 1), rand_normal(), rand_normal(),
                               rand_normal(), rand_span()));
                done++;
            end
            else
            begin
                send(rand_box());
                done++;
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        idle_on          = 1'b1;
        long_hold        = 1'b0;
        idle_cycles      = 0;
        rsp.ready        = 1'b0;
        req.valid        = 1'b0;
        req.opcode       = OP_LOAD;
        req.plane_index  = '0;
        req.normal_x     = '0;
        req.normal_y     = '0;
        req.normal_z     = '0;
        req.plane_offset = '0;
        req.min_x        = '0;
        req.min_y        = '0;
        req.min_z        = '0;
        req.max_x        = '0;
        req.max_y        = '0;
        req.max_z        = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Cleared store: zero planes keep every box inside, even an inverted one.
        send(test_item(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX));
        send(test_item(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN));

        // Axis-aligned cube |x|,|y|,|z| <= 10; zero normal components throughout.
        send(load_item(0,  ONE,    0,    0, TEN));
        send(load_item(1, -ONE,    0,    0, TEN));
        send(load_item(2,    0,  ONE,    0, TEN));
        send(load_item(3,    0, -ONE,    0, TEN));
        send(load_item(4,    0,    0,  ONE, TEN));
        send(load_item(5,    0,    0, -ONE, TEN));
        // Out-of-range slots must leave the cube alone.
        send(load_item(6, NRM_MIN, NRM_MAX, NRM_MIN, CRD_MIN));
        send(load_item(7, NRM_MAX, NRM_MIN, NRM_MAX, CRD_MAX));

        send(test_item(-ONE, -ONE, -ONE, ONE, ONE, ONE));                  // inside
        send(test_item(20 * ONE, -ONE, -ONE, 30 * ONE, ONE, ONE));         // outside
        send(test_item(-5 * ONE, -ONE, -ONE, 15 * ONE, ONE, ONE));         // straddles
        send(test_item(-TEN, -TEN, -TEN, -TEN, TEN, TEN));                 // flat on a face
        send(test_item(-TEN - 1, -ONE, -ONE, -TEN - 1, ONE, ONE));         // one LSB past
        send(test_item(5 * ONE, ONE, ONE, -5 * ONE, -ONE, -ONE));          // inverted
        send(test_item(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX));

        // Extreme normals and offsets against extreme corners.
        send(load_item(0, NRM_MIN, NRM_MAX, 0, CRD_MIN));
        send(test_item(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX));
        send(load_item(1, NRM_MAX, NRM_MIN, NRM_MIN, CRD_MAX));
        send(test_item(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX));
        send(test_item(0, 0, 0, 0, 0, 0));
        send(test_item(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN));

        random_phase(250);

        // Sender pause until the pipeline is empty, then a back-to-back burst
        // into a receiver that is holding off, so the input side backs up.
        wait_drained();
        long_hold <= 1'b1;
        repeat (HOLD_BURST_ITEMS) push_item(rand_box());

        random_phase(260);

        // Closing stretch at full rate on both sides.
        idle_on <= 1'b0;
        random_phase(150);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d plane loads (%0d more dropped as out of range) and %0d box tests",
                 loads_seen, loads_dropped, tests_seen);
        $display("Box results: %0d outside, %0d intersecting, %0d inside; %0d mismatches",
                 n_outside, n_intersect, n_inside, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/aabbfc_pkg.sv
rtl/aabbfc_req_if.sv
rtl/aabbfc_rsp_if.sv
rtl/aabb_frustum_classify_unit.sv
tb/aabbfc_checker.sv
tb/tb.sv
